FILE: design/bse_pkg.sv
// ----------------------------------------------------------------------------
// bse_pkg
// Shared codes and controller/datapath interface types for the bounded
// stack engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bse_pkg;

  // command codes
  localparam logic [2:0] CMD_PUSH   = 3'd0;
  localparam logic [2:0] CMD_POP    = 3'd1;
  localparam logic [2:0] CMD_PEEK   = 3'd2;
  localparam logic [2:0] CMD_CHANGE = 3'd3;
  localparam logic [2:0] CMD_LIST   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_BADPOS    = 2'd3;

  // fixed field widths
  localparam int CMD_W  = 3;
  localparam int WORD_W = 32;
  localparam int POS_W  = 4;
  localparam int FILL_W = 4;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;   // capture the incoming command
    logic ram_wr;    // write value into the stack memory
    logic cnt_inc;   // count up after a push
    logic cnt_dec;   // count down on a pop
    logic rd_start;  // first read of pop, peek or list
    logic rd_next;   // next entry of a list walk
    logic out_exec;  // load a result with no memory data
    logic out_read;  // load a result from memory read data
    logic out_last;  // last flag for a memory result
  } bse_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic [2:0] cmd;       // captured command
    logic [1:0] code;      // status the captured command will report
    logic       ptr_zero;  // list walk reached the bottom entry
    logic       out_busy;  // result register holds a stalled result
  } bse_stat_t;

endpackage

`default_nettype wire

FILE: design/bse_ram.sv
// ----------------------------------------------------------------------------
// bse_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds while idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/bse_ctrl.sv
// ----------------------------------------------------------------------------
// bse_ctrl
// Command sequencer: takes one command, runs it against the datapath and
// steps through the memory reads of pop, peek and list.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_ctrl import bse_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cmd_valid,
  output logic           cmd_stall,
  input  wire bse_stat_t stat,
  output bse_ctl_t       ctl
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign cmd_stall = (state != S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!(stat.cmd inside {CMD_PUSH, CMD_POP, CMD_PEEK, CMD_CHANGE, CMD_LIST})) begin
          // unused codes give no result
          state_next = S_IDLE;
        end else if (!stat.out_busy) begin
          if (stat.code != ST_OK) begin
            ctl.out_exec = 1'b1;
            state_next   = S_IDLE;
          end else begin
            case (stat.cmd)
              CMD_PUSH: begin
                ctl.ram_wr   = 1'b1;
                ctl.cnt_inc  = 1'b1;
                ctl.out_exec = 1'b1;
                state_next   = S_IDLE;
              end
              CMD_CHANGE: begin
                ctl.ram_wr   = 1'b1;
                ctl.out_exec = 1'b1;
                state_next   = S_IDLE;
              end
              CMD_POP: begin
                ctl.cnt_dec  = 1'b1;
                ctl.rd_start = 1'b1;
                state_next   = S_READ;
              end
              default: begin
                // peek and list read first
                ctl.rd_start = 1'b1;
                state_next   = S_READ;
              end
            endcase
          end
        end
      end
      S_READ: begin
        if (!stat.out_busy) begin
          ctl.out_read = 1'b1;
          ctl.out_last = (stat.cmd != CMD_LIST) || stat.ptr_zero;
          if (ctl.out_last) begin
            state_next = S_IDLE;
          end else begin
            // fetch the next entry down while this one goes out
            ctl.rd_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/bse_datapath.sv
// ----------------------------------------------------------------------------
// bse_datapath
// Command registers, fill count, stack memory, list pointer and the
// result register of the bounded stack engine.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_datapath import bse_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic        [CMD_W-1:0]  command,
  input  wire logic signed [WORD_W-1:0] value,
  input  wire logic        [POS_W-1:0]  position,
  input  wire logic                     rsp_stall,
  input  wire bse_ctl_t                 ctl,
  output bse_stat_t                     stat,
  output logic                          rsp_valid,
  output logic             [1:0]        status,
  output logic signed      [WORD_W-1:0] data,
  output logic             [FILL_W-1:0] fill_count,
  output logic                          last
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int AW   = $clog2(DEPTH);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [CMD_W-1:0]  cmd_q;
  logic [WORD_W-1:0] val_q;
  logic [POS_W-1:0]  pos_q;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [AW-1:0]     ptr;

  logic [CMPW-1:0]   cnt_ext;
  logic [CMPW-1:0]   pos_ext;
  logic [CMPW-1:0]   diff;
  logic [CW-1:0]     cnt_m1;
  logic [AW-1:0]     top_addr;
  logic [AW-1:0]     pos_addr;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic              rd_en;
  logic [WORD_W-1:0] rd_data;
  logic              empty;
  logic              full;
  logic              pos_ok;
  logic [1:0]        code;
  logic [CMPW-1:0]   fill_ext;

  // command capture
  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd_q <= command;
      val_q <= value;
      pos_q <= position;
    end
  end

  // address and range checks
  assign cnt_ext  = CMPW'(count);
  assign pos_ext  = CMPW'(pos_q);
  assign diff     = cnt_ext - pos_ext;
  assign cnt_m1   = count - CW'(1);
  assign top_addr = cnt_m1[AW-1:0];
  assign pos_addr = diff[AW-1:0];
  assign empty    = (count == '0);
  assign full     = (count == CW'(DEPTH));
  assign pos_ok   = (pos_q != '0) && (pos_ext <= cnt_ext);

  // status of the captured command
  always_comb begin
    case (cmd_q)
      CMD_PUSH:   code = full ? ST_OVERFLOW : ST_OK;
      CMD_PEEK,
      CMD_CHANGE: code = empty ? ST_UNDERFLOW : (pos_ok ? ST_OK : ST_BADPOS);
      default:    code = empty ? ST_UNDERFLOW : ST_OK;
    endcase
  end

  // fill count
  always_comb begin
    count_next = count;
    if (ctl.cnt_inc) begin
      count_next = count + CW'(1);
    end else if (ctl.cnt_dec) begin
      count_next = cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // list walk pointer, tracks the entry in the read register
  always_ff @(posedge clk) begin
    if (ctl.rd_start || ctl.rd_next) begin
      ptr <= rd_addr;
    end
  end

  // stack memory ports
  assign wr_addr = (cmd_q == CMD_PUSH) ? count[AW-1:0] : pos_addr;
  assign rd_en   = ctl.rd_start || ctl.rd_next;

  always_comb begin
    if (ctl.rd_next) begin
      rd_addr = ptr - AW'(1);
    end else if (cmd_q == CMD_PEEK) begin
      rd_addr = pos_addr;
    end else begin
      rd_addr = top_addr;
    end
  end

  bse_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ctl.ram_wr),
    .wr_addr (wr_addr),
    .wr_data (val_q),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // result register
  assign fill_ext = CMPW'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.out_exec || ctl.out_read) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_exec) begin
      status     <= code;
      data       <= '0;
      fill_count <= fill_ext[FILL_W-1:0];
      last       <= 1'b1;
    end else if (ctl.out_read) begin
      status     <= ST_OK;
      data       <= rd_data;
      fill_count <= fill_ext[FILL_W-1:0];
      last       <= ctl.out_last;
    end
  end

  // status to the controller
  assign stat.cmd      = cmd_q;
  assign stat.code     = code;
  assign stat.ptr_zero = (ptr == '0);
  assign stat.out_busy = rsp_valid && rsp_stall;

endmodule

`default_nettype wire

FILE: design/bounded_stack_engine_core.sv
// ----------------------------------------------------------------------------
// bounded_stack_engine_core
// Fixed-depth stack of signed 32-bit words with push, pop, peek, change
// and list commands, each answered with status and fill count.
// ----------------------------------------------------------------------------
// One command is taken at a time. After a transfer on the command channel
// the engine checks the command against the fill count in its check state;
// push and change (and every error) then put their single result into the
// output register, and the command channel is busy until then. Pop and
// peek add a read state for the registered memory read. List reads from
// the top down and delivers one entry per cycle while the result channel
// is not stalled. The output register lets the next command be taken
// while the final result still waits. Command codes 5 to 7 are dropped
// without a result. Entries are never cleared: only entries below the
// fill count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_stack_engine_core import bse_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cmd_valid,
  output logic                          cmd_stall,
  input  wire logic        [CMD_W-1:0]  command,
  input  wire logic signed [WORD_W-1:0] value,
  input  wire logic        [POS_W-1:0]  position,
  output logic                          rsp_valid,
  input  wire logic                     rsp_stall,
  output logic             [1:0]        status,
  output logic signed      [WORD_W-1:0] data,
  output logic             [FILL_W-1:0] fill_count,
  output logic                          last
);

  localparam int DW = $clog2(DEPTH + 1) + FILL_W;
  localparam logic [DW-1:0] DEPTH_V = DW'(DEPTH);

  bse_ctl_t  ctl;
  bse_stat_t stat;

  // command sequencer
  bse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  // storage and result datapath
  bse_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .command    (command),
    .value      (value),
    .position   (position),
    .rsp_stall  (rsp_stall),
    .ctl        (ctl),
    .stat       (stat),
    .rsp_valid  (rsp_valid),
    .status     (status),
    .data       (data),
    .fill_count (fill_count),
    .last       (last)
  );

  // a taken command stalls the command channel in the following cycle
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> cmd_stall)
    else $error("command taken back to back");

  // error results carry zero data and end the command
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (status != ST_OK)) |-> ((data == '0) && last))
    else $error("error result with data or without last");

  // overflow only reported on a full stack
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (status == ST_OVERFLOW)) |-> (fill_count == DEPTH_V[FILL_W-1:0]))
    else $error("overflow below full depth");

endmodule

`default_nettype wire
